>>> rtl/core/bilinear_table_interpolation_top_macros.svh
// assertion macros for the bilinear table interpolator
// used by bilinear_table_interpolation_top, expects i_clk and i_rst_n in scope
`ifndef BILINEAR_TABLE_INTERPOLATION_TOP_MACROS_SVH
`define BILINEAR_TABLE_INTERPOLATION_TOP_MACROS_SVH

// consequent checked in the same cycle
`define BTI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bti_pkg.sv
// types and codes shared by the bilinear table interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bti_pkg;

    // command codes
    localparam logic [2:0] CMD_WR_ROW = 3'd0;
    localparam logic [2:0] CMD_WR_COL = 3'd1;
    localparam logic [2:0] CMD_WR_CELL = 3'd2;
    localparam logic [2:0] CMD_LOOKUP_2D = 3'd3;
    localparam logic [2:0] CMD_LOOKUP_1D = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO_WIDTH = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    // configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // saturation limits
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // quotient bits of the weight divider
    localparam int DIV_STEPS = 49;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [3:0]         row_sel;
        logic [3:0]         col_sel;
        logic signed [31:0] data_word;
        logic signed [31:0] row_key;
        logic signed [31:0] col_key;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [1:0]         status;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/core/bilinear_table_interpolation_top.sv
// bilinear table interpolator top level: breakpoint and cell memories, sequencer, lerp unit
// depends on bti_pkg, bti_ram and bilinear_table_interpolation_top_macros.svh
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_stall      i_item (bti_pkg::t_in_item)
//  output    out        o_valid / i_stall      o_item (bti_pkg::t_out_item)
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// a write item is written to its memory at acceptance
// a lookup searches its axes serially (row then column; 1-D searches columns only),
// one breakpoint read per S_SRD/S_SCMP pair, then fetches and runs the lerp steps
// (49-step divider, 4-digit multiplier)
// reset is synchronous; memories are not cleared, the output register holds one
// finished item so the next item is taken while the result waits
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_table_interpolation_top_macros.svh"

module bilinear_table_interpolation_top #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire bti_pkg::t_in_item i_item,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output bti_pkg::t_out_item   o_item,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [4:0]      i_cfg_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int CAW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int SW = (RW > CW) ? RW : CW;
    localparam int NW = (RCW > CCW) ? RCW : CCW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SRD   = 10'b00_0000_0010,
        S_SCMP  = 10'b00_0000_0100,
        S_FETCH = 10'b00_0000_1000,
        S_LSET  = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_ADD   = 10'b00_1000_0000,
        S_SAT   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_LAST  = 2'd1,
        PH_SCAN  = 2'd2
    } t_phase;

    function automatic logic [32:0] abs33(input logic [32:0] v);
        abs33 = v[32] ? (33'd0 - v) : v;
    endfunction

    // control registers
    t_state            r_state;
    t_phase            r_sph;
    logic              r_axis;
    logic [SW-1:0]     r_sidx;
    logic [2:0]        r_fi;
    logic [1:0]        r_step;
    logic [5:0]        r_cnt;
    logic [1:0]        r_mcnt;
    logic              r_is2d;
    logic              r_zw;
    logic              r_sat;
    logic              r_ovalid;
    logic [4:0]        r_row_count;
    logic [4:0]        r_col_count;

    // payload registers
    logic [RW-1:0]     r_ir;
    logic [CW-1:0]     r_ic;
    logic [31:0]       r_rkey;
    logic [31:0]       r_ckey;
    logic [31:0]       r_cx0, r_cx1, r_rx0, r_rx1;
    logic [31:0]       r_y00, r_y01, r_y10, r_y11;
    logic [31:0]       r_v0, r_v1, r_res, r_y0;
    logic [32:0]       r_dmag, r_rem, r_a;
    logic [48:0]       r_dvd;
    logic              r_pneg;
    logic [81:0]       r_acc;
    logic [83:0]       r_sum;
    bti_pkg::t_out_item r_out;

    // memory ports
    logic              w_row_we, w_col_we, w_cell_we;
    logic [RW-1:0]     w_row_waddr, w_row_raddr;
    logic [CW-1:0]     w_col_waddr, w_col_raddr;
    logic [CAW-1:0]    w_cell_waddr, w_cell_raddr;
    logic [31:0]       w_row_q, w_col_q, w_cell_q;

    logic              w_in_acc, w_out_acc, w_load_out;
    logic [RCW-1:0]    w_nr;
    logic [CCW-1:0]    w_nc;
    logic [NW-1:0]     w_n;
    logic [SW-1:0]     w_last, w_seg_hi;
    logic signed [31:0] w_key, w_q;
    logic [RW-1:0]     w_ir1d;
    logic [31:0]       w_cr, w_cc;

    logic [31:0]       w_x0, w_x1, w_y0, w_y1, w_x;
    logic [32:0]       w_d, w_dx, w_dy;
    logic [33:0]       w_rem_sh;
    logic              w_ge;
    logic [32:0]       n_rem;
    logic [63:0]       w_q64;
    logic [15:0]       w_dig;
    logic [48:0]       w_pp;
    logic [81:0]       n_acc;
    logic [83:0]       n_sum;
    logic              w_fit;
    logic [31:0]       w_val;

    assign w_in_acc = i_valid && !o_stall;
    assign w_out_acc = r_ovalid && !i_stall;
    assign w_load_out = (r_state == S_DONE) && (!r_ovalid || !i_stall);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item = r_out;

    // effective breakpoint counts
    assign w_nr = (r_row_count < 5'd2) ? RCW'(2) :
                  ((32'(r_row_count) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(r_row_count));
    assign w_nc = (r_col_count < 5'd2) ? CCW'(2) :
                  ((32'(r_col_count) > 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(r_col_count));

    // write items go straight to memory
    assign w_row_we = w_in_acc && (i_item.cmd == bti_pkg::CMD_WR_ROW)
                      && (32'(i_item.row_sel) < 32'(MAX_ROWS));
    assign w_col_we = w_in_acc && (i_item.cmd == bti_pkg::CMD_WR_COL)
                      && (32'(i_item.col_sel) < 32'(MAX_COLS));
    assign w_cell_we = w_in_acc && (i_item.cmd == bti_pkg::CMD_WR_CELL)
                       && (32'(i_item.row_sel) < 32'(MAX_ROWS))
                       && (32'(i_item.col_sel) < 32'(MAX_COLS));
    assign w_row_waddr = RW'(i_item.row_sel);
    assign w_col_waddr = CW'(i_item.col_sel);
    assign w_cell_waddr = CAW'(32'(i_item.row_sel) * 32'(MAX_COLS) + 32'(i_item.col_sel));

    // 1-D row clamp
    assign w_ir1d = (32'(i_item.row_sel) < 32'(w_nr)) ? RW'(i_item.row_sel)
                                                      : RW'(w_nr - RCW'(1));

    // search operands
    assign w_key = r_axis ? r_ckey : r_rkey;
    assign w_q = r_axis ? w_col_q : w_row_q;
    assign w_n = r_axis ? NW'(w_nc) : NW'(w_nr);
    assign w_last = SW'(w_n - NW'(1));
    assign w_seg_hi = SW'(w_n - NW'(2));

    // read addresses: search index, or the fetch sequence
    assign w_cr = 32'(r_ir) + ((r_fi >= 3'd2) ? 32'd1 : 32'd0);
    assign w_cc = 32'(r_ic) + 32'(r_fi[0]);
    assign w_cell_raddr = CAW'(w_cr * 32'(MAX_COLS) + w_cc);
    assign w_row_raddr = (r_state == S_FETCH) ? ((r_fi == 3'd0) ? r_ir : r_ir + RW'(1))
                                              : RW'(r_sidx);
    assign w_col_raddr = (r_state == S_FETCH) ? ((r_fi == 3'd0) ? r_ic : r_ic + CW'(1))
                                              : CW'(r_sidx);

    bti_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (i_item.data_word),
        .i_raddr (w_row_raddr),
        .o_rdata (w_row_q)
    );

    bti_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (w_col_waddr),
        .i_wdata (i_item.data_word),
        .i_raddr (w_col_raddr),
        .o_rdata (w_col_q)
    );

    bti_ram #(.WIDTH(32), .DEPTH(MAX_ROWS * MAX_COLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (i_item.data_word),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_q)
    );

    // lerp step operands
    always_comb begin
        case (r_step)
            2'd0: begin
                w_x0 = r_cx0; w_x1 = r_cx1; w_y0 = r_y00; w_y1 = r_y01; w_x = r_ckey;
            end
            2'd1: begin
                w_x0 = r_cx0; w_x1 = r_cx1; w_y0 = r_y10; w_y1 = r_y11; w_x = r_ckey;
            end
            default: begin
                w_x0 = r_rx0; w_x1 = r_rx1; w_y0 = r_v0; w_y1 = r_v1; w_x = r_rkey;
            end
        endcase
    end

    assign w_d = {w_x1[31], w_x1} - {w_x0[31], w_x0};
    assign w_dx = {w_x[31], w_x} - {w_x0[31], w_x0};
    assign w_dy = {w_y1[31], w_y1} - {w_y0[31], w_y0};

    // restoring divider step
    assign w_rem_sh = {r_rem, r_dvd[48]};
    assign w_ge = (w_rem_sh >= {1'b0, r_dmag});
    assign n_rem = w_ge ? 33'(w_rem_sh - {1'b0, r_dmag}) : 33'(w_rem_sh);

    // multiplier digit step, top digit first
    assign w_q64 = {15'd0, r_dvd};
    assign w_dig = w_q64[{~r_mcnt, 4'd0} +: 16];
    assign w_pp = r_a * w_dig;
    assign n_acc = {r_acc[65:0], 16'd0} + {33'd0, w_pp};

    // signed product plus y0 scaled
    assign n_sum = (r_pneg ? (84'd0 - {2'b00, r_acc}) : {2'b00, r_acc})
                   + {{36{r_y0[31]}}, r_y0, 16'd0};

    // range check and saturation
    assign w_fit = (&r_sum[83:47]) | ~(|r_sum[83:47]);
    assign w_val = w_fit ? r_sum[47:16] : (r_sum[83] ? bti_pkg::SAT_MIN : bti_pkg::SAT_MAX);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sph <= PH_FIRST;
            r_axis <= 1'b0;
            r_sidx <= '0;
            r_fi <= '0;
            r_step <= '0;
            r_cnt <= '0;
            r_mcnt <= '0;
            r_is2d <= 1'b0;
            r_zw <= 1'b0;
            r_sat <= 1'b0;
            r_ovalid <= 1'b0;
            r_row_count <= 5'd2;
            r_col_count <= 5'd2;
        end else begin
            // configuration writes
            if (i_cfg_we && (i_cfg_index == bti_pkg::REG_ROW_COUNT)) begin
                r_row_count <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == bti_pkg::REG_COL_COUNT)) begin
                r_col_count <= i_cfg_data;
            end

            // output register valid
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (w_out_acc) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && ((i_item.cmd == bti_pkg::CMD_LOOKUP_2D)
                                     || (i_item.cmd == bti_pkg::CMD_LOOKUP_1D))) begin
                        r_is2d <= (i_item.cmd == bti_pkg::CMD_LOOKUP_2D);
                        r_axis <= (i_item.cmd == bti_pkg::CMD_LOOKUP_1D);
                        r_sph <= PH_FIRST;
                        r_sidx <= '0;
                        r_step <= 2'd0;
                        r_zw <= 1'b0;
                        r_sat <= 1'b0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    r_state <= S_SRD;
                    case (r_sph)
                        PH_FIRST: begin
                            if (w_key < w_q) begin
                                r_state <= r_axis ? S_FETCH : S_SRD;
                                r_axis <= 1'b1;
                                r_sidx <= '0;
                                r_fi <= '0;
                            end else begin
                                r_sph <= PH_LAST;
                                r_sidx <= w_last;
                            end
                        end
                        PH_LAST: begin
                            if (w_key >= w_q) begin
                                r_state <= r_axis ? S_FETCH : S_SRD;
                                r_axis <= 1'b1;
                                r_sph <= PH_FIRST;
                                r_sidx <= '0;
                                r_fi <= '0;
                            end else begin
                                r_sph <= PH_SCAN;
                                r_sidx <= SW'(1);
                            end
                        end
                        default: begin
                            if (w_q >= w_key) begin
                                r_state <= r_axis ? S_FETCH : S_SRD;
                                r_axis <= 1'b1;
                                r_sph <= PH_FIRST;
                                r_sidx <= '0;
                                r_fi <= '0;
                            end else begin
                                r_sidx <= r_sidx + SW'(1);
                            end
                        end
                    endcase
                end
                S_FETCH: begin
                    r_fi <= r_fi + 3'd1;
                    if (r_fi == 3'd4) begin
                        r_state <= S_LSET;
                    end
                end
                S_LSET: begin
                    r_cnt <= '0;
                    r_mcnt <= '0;
                    if (w_d == 33'd0) begin
                        r_zw <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(bti_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (!w_fit) begin
                        r_sat <= 1'b1;
                    end
                    if (r_is2d && (r_step != 2'd2)) begin
                        r_step <= r_step + 2'd1;
                        r_state <= S_LSET;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rkey <= i_item.row_key;
                r_ckey <= i_item.col_key;
                if (i_item.cmd == bti_pkg::CMD_LOOKUP_1D) begin
                    r_ir <= w_ir1d;
                end
            end
            S_SCMP: begin
                // segment found: store the index for the axis in progress
                if (((r_sph == PH_FIRST) && (w_key < w_q))) begin
                    if (r_axis) r_ic <= '0;
                    else r_ir <= '0;
                end else if ((r_sph == PH_LAST) && (w_key >= w_q)) begin
                    if (r_axis) r_ic <= CW'(w_seg_hi);
                    else r_ir <= RW'(w_seg_hi);
                end else if ((r_sph == PH_SCAN) && (w_q >= w_key)) begin
                    if (r_axis) r_ic <= CW'(r_sidx - SW'(1));
                    else r_ir <= RW'(r_sidx - SW'(1));
                end
            end
            S_FETCH: begin
                case (r_fi)
                    3'd1: begin
                        r_cx0 <= w_col_q; r_rx0 <= w_row_q; r_y00 <= w_cell_q;
                    end
                    3'd2: begin
                        r_cx1 <= w_col_q; r_rx1 <= w_row_q; r_y01 <= w_cell_q;
                    end
                    3'd3: r_y10 <= w_cell_q;
                    3'd4: r_y11 <= w_cell_q;
                    default: ;
                endcase
            end
            S_LSET: begin
                r_dmag <= abs33(w_d);
                r_dvd <= {abs33(w_dx), 16'd0};
                r_rem <= '0;
                r_a <= abs33(w_dy);
                r_pneg <= w_d[32] ^ w_dx[32] ^ w_dy[32];
                r_y0 <= w_y0;
                r_acc <= '0;
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[47:0], w_ge};
            end
            S_MUL: begin
                r_acc <= n_acc;
            end
            S_ADD: begin
                r_sum <= n_sum;
            end
            S_SAT: begin
                case (r_step)
                    2'd0: r_v0 <= w_val;
                    2'd1: r_v1 <= w_val;
                    default: ;
                endcase
                r_res <= w_val;
            end
            S_DONE: begin
                if (w_load_out) begin
                    if (r_zw) begin
                        r_out.interp_value <= '0;
                        r_out.status <= bti_pkg::ST_ZERO_WIDTH;
                    end else begin
                        r_out.interp_value <= r_res;
                        r_out.status <= r_sat ? bti_pkg::ST_SATURATED : bti_pkg::ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    // checks
    `BTI_ASSERT_SAME(a_write_only_idle, (w_row_we || w_col_we || w_cell_we), (r_state == S_IDLE), "memory written outside idle")
    `BTI_ASSERT_SAME(a_scan_in_range, ((r_state == S_SCMP) && (r_sph == PH_SCAN)), (r_sidx <= w_last), "breakpoint scan ran past the last entry")
    `BTI_ASSERT_SAME(a_div_rem_below, (r_state == S_DIV), (r_rem < r_dmag), "divider remainder not below divisor")
    `BTI_ASSERT_NEXT(a_done_loads_out, w_load_out, (r_ovalid && (r_state == S_IDLE)), "finished item not loaded into output register")

endmodule

`default_nettype wire

>>> rtl/core/bti_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
